// File: src/fle_pkg.sv
`default_nettype none

package fle_pkg;

    // Frame geometry and field widths
    localparam int FLE_FRAME_BYTES = 20;
    localparam int FLE_BYTE_W      = 8;
    localparam int FLE_POS_W       = 6;

    // Configuration port
    localparam int FLE_CFG_IDX_W = 1;
    localparam logic [FLE_CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
    localparam logic [FLE_CFG_IDX_W-1:0] REG_STOP_MARKER  = 1'b1;

    localparam logic [FLE_BYTE_W-1:0] START_MARKER_RST = 8'hAB;
    localparam logic [FLE_BYTE_W-1:0] STOP_MARKER_RST  = 8'hBA;

    // What one window cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT1,
        CELL_SHIFT2
    } t_cell_op;

    // Control of one output cell
    typedef struct packed {
        logic load;
        logic shift;
    } t_out_ctl;

endpackage

`default_nettype wire

// File: src/fle_win_cell.sv
`default_nettype none

module fle_win_cell (
    input  wire                               i_clk,
    input  fle_pkg::t_cell_op                 i_op,
    input  wire  [fle_pkg::FLE_BYTE_W-1:0]    i_rx_byte,
    input  wire  [fle_pkg::FLE_BYTE_W-1:0]    i_next1,
    input  wire  [fle_pkg::FLE_BYTE_W-1:0]    i_next2,
    output logic [fle_pkg::FLE_BYTE_W-1:0]    o_byte
);
    import fle_pkg::*;

    logic [FLE_BYTE_W-1:0] r_byte;
    logic [FLE_BYTE_W-1:0] n_byte;

    // store new byte, move one or two places toward the head, or hold
    always_comb begin
        unique case (i_op)
            CELL_LOAD:   n_byte = i_rx_byte;
            CELL_SHIFT1: n_byte = i_next1;
            CELL_SHIFT2: n_byte = i_next2;
            default:     n_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// File: src/fle_out_cell.sv
`default_nettype none

module fle_out_cell (
    input  wire                               i_clk,
    input  fle_pkg::t_out_ctl                 i_ctl,
    input  wire  [fle_pkg::FLE_BYTE_W-1:0]    i_load_byte,
    input  wire  [fle_pkg::FLE_BYTE_W-1:0]    i_next_byte,
    output logic [fle_pkg::FLE_BYTE_W-1:0]    o_byte
);
    import fle_pkg::*;

    logic [FLE_BYTE_W-1:0] r_byte;
    logic [FLE_BYTE_W-1:0] n_byte;

    // parallel load of a frame, then shift toward the output one per request
    always_comb begin
        priority if (i_ctl.load) begin
            n_byte = i_load_byte;
        end else if (i_ctl.shift) begin
            n_byte = i_next_byte;
        end else begin
            n_byte = r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// File: src/fixed_length_frame_extractor.sv
// The first byte of a frame is valid in the cycle after the byte that completes it is taken.
// Throughput: one received byte per cycle unless the input stalls; a frame drains
// at one byte per cycle unless the receiver stalls. Input stalls only when a frame
// could complete while the previous frame still drains, which is set by the single
// output shift chain. Reset (synchronous, active low) clears fill count and output
// state and restores both markers; window cell contents are not cleared.
`default_nettype none

module fixed_length_frame_extractor #(
    parameter int FRAME_BYTES = fle_pkg::FLE_FRAME_BYTES
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_we,
    input  wire  [fle_pkg::FLE_CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [fle_pkg::FLE_BYTE_W-1:0]       i_cfg_data,
    // received bytes
    input  wire                                  i_rx_valid,
    output logic                                 o_rx_stall,
    input  wire  [fle_pkg::FLE_BYTE_W-1:0]       i_rx_byte,
    // frame bytes
    output logic                                 o_pkt_valid,
    input  wire                                  i_pkt_stall,
    output logic [fle_pkg::FLE_BYTE_W-1:0]       o_packet_byte,
    output logic [fle_pkg::FLE_POS_W-1:0]        o_byte_position,
    output logic                                 o_last_byte
);
    import fle_pkg::*;

    localparam int CELLS = FRAME_BYTES - 1;
    localparam int CNT_W = $clog2(FRAME_BYTES);

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_APPEND,
        STEP_DROP1,
        STEP_DROP2,
        STEP_EMIT
    } t_step;

    logic [FLE_BYTE_W-1:0] r_start;
    logic [FLE_BYTE_W-1:0] r_stop;
    logic [CNT_W-1:0]      r_fill;
    logic [CNT_W-1:0]      n_fill;
    logic                  r_busy;
    logic                  n_busy;
    logic [FLE_POS_W-1:0]  r_pos;
    logic [FLE_POS_W-1:0]  n_pos;

    logic [FLE_BYTE_W-1:0] w_cell [CELLS];
    logic [FLE_BYTE_W-1:0] w_out  [FRAME_BYTES];
    t_step                 step;
    logic                  rx_take;
    logic                  out_take;
    t_out_ctl              out_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_MARKER_RST;
            r_stop  <= STOP_MARKER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_MARKER: r_start <= i_cfg_data;
                REG_STOP_MARKER:  r_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a full window would need the output chain while it still drains
    assign o_rx_stall = r_busy && (r_fill == CNT_W'(FRAME_BYTES - 1));
    assign rx_take    = i_rx_valid && !o_rx_stall;
    assign out_take   = r_busy && !i_pkt_stall;

    // frame check on the window as it stands with the new byte appended
    always_comb begin
        priority if (!rx_take) begin
            step = STEP_IDLE;
        end else if (r_fill != CNT_W'(FRAME_BYTES - 1)) begin
            step = STEP_APPEND;
        end else if (w_cell[0] != r_start) begin
            step = STEP_DROP1;
        end else if (w_cell[1] != r_start) begin
            step = STEP_DROP2;
        end else if (i_rx_byte == r_stop && w_cell[CELLS-1] == r_stop) begin
            step = STEP_EMIT;
        end else begin
            step = STEP_DROP1;
        end
    end

    // fill count
    always_comb begin
        unique case (step)
            STEP_APPEND: n_fill = r_fill + 1'b1;
            STEP_DROP1:  n_fill = CNT_W'(FRAME_BYTES - 1);
            STEP_DROP2:  n_fill = CNT_W'(FRAME_BYTES - 2);
            STEP_EMIT:   n_fill = '0;
            default:     n_fill = r_fill;
        endcase
    end

    // window chain: cell i holds the byte at frame position i
    for (genvar gi = 0; gi < CELLS; gi++) begin : g_win
        t_cell_op              cell_op;
        logic [FLE_BYTE_W-1:0] next1;
        logic [FLE_BYTE_W-1:0] next2;

        if (gi + 1 < CELLS) begin : g_n1
            assign next1 = w_cell[gi+1];
        end else begin : g_n1_rx
            assign next1 = i_rx_byte;
        end

        if (gi + 2 < CELLS) begin : g_n2
            assign next2 = w_cell[gi+2];
        end else begin : g_n2_rx
            assign next2 = i_rx_byte;
        end

        always_comb begin
            unique case (step)
                STEP_APPEND: cell_op = (r_fill == CNT_W'(gi)) ? CELL_LOAD : CELL_HOLD;
                STEP_DROP1:  cell_op = CELL_SHIFT1;
                STEP_DROP2:  cell_op = CELL_SHIFT2;
                default:     cell_op = CELL_HOLD;
            endcase
        end

        fle_win_cell u_cell (
            .i_clk     (i_clk),
            .i_op      (cell_op),
            .i_rx_byte (i_rx_byte),
            .i_next1   (next1),
            .i_next2   (next2),
            .o_byte    (w_cell[gi])
        );
    end

    // output chain: loaded with the whole frame, drained from cell 0
    assign out_ctl.load  = (step == STEP_EMIT);
    assign out_ctl.shift = out_take;

    for (genvar go = 0; go < FRAME_BYTES; go++) begin : g_out
        logic [FLE_BYTE_W-1:0] load_byte;
        logic [FLE_BYTE_W-1:0] next_byte;

        if (go < CELLS) begin : g_ld
            assign load_byte = w_cell[go];
        end else begin : g_ld_rx
            assign load_byte = i_rx_byte;
        end

        if (go + 1 < FRAME_BYTES) begin : g_nx
            assign next_byte = w_out[go+1];
        end else begin : g_nx_end
            assign next_byte = '0;
        end

        fle_out_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (out_ctl),
            .i_load_byte (load_byte),
            .i_next_byte (next_byte),
            .o_byte      (w_out[go])
        );
    end

    // output position and busy flag
    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (out_ctl.load) begin
            n_busy = 1'b1;
            n_pos  = '0;
        end else if (out_take) begin
            if (o_last_byte) begin
                n_busy = 1'b0;
            end
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_fill <= n_fill;
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    assign o_pkt_valid     = r_busy;
    assign o_packet_byte   = w_out[0];
    assign o_byte_position = r_pos;
    assign o_last_byte     = (r_pos == FLE_POS_W'(FRAME_BYTES - 1));

endmodule

`default_nettype wire

// File: src/fle_checker.sv
`default_nettype none

module fle_checker #(
    parameter int FRAME_BYTES = fle_pkg::FLE_FRAME_BYTES
) (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  o_pkt_valid,
    input wire                                  i_pkt_stall,
    input wire  [fle_pkg::FLE_BYTE_W-1:0]       o_packet_byte,
    input wire  [fle_pkg::FLE_POS_W-1:0]        o_byte_position,
    input wire                                  o_last_byte
);
    import fle_pkg::*;

    // a stalled frame byte holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pkt_valid && i_pkt_stall |=>
            o_pkt_valid && $stable(o_packet_byte) && $stable(o_byte_position))
        else $error("frame byte changed while stalled");

    // positions run up by one inside a frame
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pkt_valid && !i_pkt_stall && !o_last_byte |=>
            o_pkt_valid && (o_byte_position == $past(o_byte_position) + 1'b1))
        else $error("frame byte position skipped");

    // last flag marks exactly the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pkt_valid |-> (o_last_byte == (o_byte_position == FLE_POS_W'(FRAME_BYTES - 1))))
        else $error("last flag at wrong position");

    // a new frame needs a full window of fresh bytes, so none follows at once
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pkt_valid && !i_pkt_stall && o_last_byte |=> !o_pkt_valid)
        else $error("frame started right after previous frame");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pkt_valid)
        else $error("frame byte valid after reset");

endmodule

bind fixed_length_frame_extractor fle_checker #(.FRAME_BYTES(FRAME_BYTES)) u_fle_checker (.*);

`default_nettype wire

// File: sim/fixed_length_frame_extractor_tb.sv
`timescale 1ns / 100ps

module fixed_length_frame_extractor_tb;
    import fle_pkg::*;

    localparam int FRAME_BYTES = FLE_FRAME_BYTES;

    // Directed table: one received byte per row, plus whether that byte completes a frame
    localparam logic ROW_QUIET = 1'b0;
    localparam logic ROW_FRAME = 1'b1;
    localparam int DIR_ROWS_N = 24;
    localparam logic [0:DIR_ROWS_N-1][8:0] DIR_ROWS = {
        {ROW_QUIET, 8'h00},             // window fills to here, then: bad first start byte
        {ROW_QUIET, START_MARKER_RST},
        {ROW_QUIET, 8'hFF},             // bad second start byte, drops two
        {ROW_QUIET, START_MARKER_RST},  // stop check fails on this alignment
        {ROW_QUIET, START_MARKER_RST},  // accepted frame starts here
        {ROW_QUIET, START_MARKER_RST},
        {ROW_QUIET, 8'h00}, {ROW_QUIET, 8'hFF}, {ROW_QUIET, 8'h01}, {ROW_QUIET, 8'h80},
        {ROW_QUIET, 8'h7F},
        {ROW_QUIET, STOP_MARKER_RST},   // stop markers inside the payload
        {ROW_QUIET, STOP_MARKER_RST},
        {ROW_QUIET, START_MARKER_RST},  // start marker inside the payload
        {ROW_QUIET, 8'h55}, {ROW_QUIET, 8'hAA}, {ROW_QUIET, 8'hFE}, {ROW_QUIET, 8'h02},
        {ROW_QUIET, 8'h40},
        {ROW_QUIET, 8'h10},             // window full: first check
        {ROW_QUIET, 8'hC3},
        {ROW_QUIET, 8'h00},
        {ROW_QUIET, STOP_MARKER_RST},   // only one stop marker at the end: drop one
        {ROW_FRAME, STOP_MARKER_RST}    // both stop markers in place: frame out
    };

    typedef struct packed {
        logic [FLE_BYTE_W-1:0] pkt_byte;
        logic [FLE_POS_W-1:0]  pos;
        logic                  last;
    } t_frame_byte;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [FLE_CFG_IDX_W-1:0]      i_cfg_idx;
    logic [FLE_BYTE_W-1:0]         i_cfg_data;
    logic                          i_rx_valid;
    logic                          o_rx_stall;
    logic [FLE_BYTE_W-1:0]         i_rx_byte;
    logic                          o_pkt_valid;
    logic                          i_pkt_stall;
    logic [FLE_BYTE_W-1:0]         o_packet_byte;
    logic [FLE_POS_W-1:0]          o_byte_position;
    logic                          o_last_byte;

    // Predictor state
    logic [FLE_BYTE_W-1:0] mk_start;
    logic [FLE_BYTE_W-1:0] mk_stop;
    logic [FLE_BYTE_W-1:0] frame_win [FRAME_BYTES];
    int unsigned           win_fill;
    t_frame_byte           frame_bytes_due [$];

    int unsigned n_mismatches = 0;
    int unsigned frames_seen  = 0;
    int unsigned items_sent   = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;

    fixed_length_frame_extractor DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_pkt_valid     (o_pkt_valid),
        .i_pkt_stall     (i_pkt_stall),
        .o_packet_byte   (o_packet_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        n_mismatches++;
        if (n_mismatches <= 10)
            $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    // Drop n oldest bytes from the predicted window
    function automatic void shift_window(input int unsigned n);
        for (int i = 0; i + n < win_fill; i++)
            frame_win[i] = frame_win[i + n];
        win_fill = win_fill - n;
    endfunction

    // Append one byte; when the window is full, check markers and queue a frame if it passes
    function automatic void predict_frame(input logic [FLE_BYTE_W-1:0] b);
        t_frame_byte want;
        if (win_fill < FRAME_BYTES) begin
            frame_win[win_fill] = b;
            win_fill++;
        end
        if (win_fill == FRAME_BYTES) begin
            if (frame_win[0] != mk_start) begin
                shift_window(1);
            end else if (frame_win[1] != mk_start) begin
                shift_window(2);
            end else if (frame_win[FRAME_BYTES-1] == mk_stop &&
                         frame_win[FRAME_BYTES-2] == mk_stop) begin
                for (int k = 0; k < FRAME_BYTES; k++) begin
                    want.pkt_byte = frame_win[k];
                    want.pos      = FLE_POS_W'(k);
                    want.last     = (k == FRAME_BYTES - 1);
                    frame_bytes_due.push_back(want);
                end
                win_fill = 0;
            end else begin
                // stop check failed: slide by one so the search keeps going
                shift_window(1);
            end
        end
    endfunction

    // Rising edge: register writes and accepted requests feed the predictor, frame bytes are checked
    always @(posedge i_clk) begin : watch
        t_frame_byte want;
        if (!i_rst_n) begin
            mk_start = START_MARKER_RST;
            mk_stop  = STOP_MARKER_RST;
            win_fill = 0;
            frame_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_MARKER: mk_start = i_cfg_data;
                    REG_STOP_MARKER:  mk_stop  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx_valid && !o_rx_stall)
                predict_frame(i_rx_byte);
            if (o_pkt_valid && !i_pkt_stall) begin
                if (o_last_byte === 1'b1)
                    frames_seen++;
                if (frame_bytes_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected frame byte %h pos %0d last %b",
                                            o_packet_byte, o_byte_position, o_last_byte));
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (o_packet_byte !== want.pkt_byte || o_byte_position !== want.pos ||
                        o_last_byte !== want.last)
                        note_mismatch($sformatf(
                            "expected byte %h pos %0d last %b, got byte %h pos %0d last %b",
                            want.pkt_byte, want.pos, want.last,
                            o_packet_byte, o_byte_position, o_last_byte));
                end
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk)
        i_pkt_stall <= ($urandom_range(99) < rcv_stall_pct);

    // Present one request at a falling edge and hold it until accepted
    task automatic send_rx(input logic [FLE_BYTE_W-1:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Mostly random bytes, markers now and then
    function automatic logic [FLE_BYTE_W-1:0] rand_rx_byte();
        case ($urandom_range(7))
            0:       return mk_start;
            1:       return mk_stop;
            default: return FLE_BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // One frame with current markers; a broken one has a single marker bit flipped
    task automatic send_frame(input bit broken);
        int unsigned           bad_pos;
        logic [FLE_BYTE_W-1:0] b;
        bad_pos = FRAME_BYTES;
        if (broken)
            bad_pos = $urandom_range(1) ? $urandom_range(1) : FRAME_BYTES - 1 - $urandom_range(1);
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (k < 2)
                b = mk_start;
            else if (k >= FRAME_BYTES - 2)
                b = mk_stop;
            else
                b = rand_rx_byte();
            if (k == bad_pos)
                b = b ^ (8'h01 << $urandom_range(7));
            send_rx(b);
        end
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(9);
            if (pick == 0)
                repeat ($urandom_range(1, 3)) send_rx(rand_rx_byte());
            else
                send_frame(pick == 1);
        end
    endtask

    // Sender holds off until every predicted frame byte has come out
    task automatic drain_frames();
        int unsigned guard;
        guard = 0;
        i_rx_valid <= 1'b0;
        while (frame_bytes_due.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_markers(input logic [FLE_BYTE_W-1:0] start_val,
                                 input logic [FLE_BYTE_W-1:0] stop_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_START_MARKER;
        i_cfg_data <= start_val;
        @(negedge i_clk);
        i_cfg_idx  <= REG_STOP_MARKER;
        i_cfg_data <= stop_val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [8:0]            row;
        int unsigned           frames_typed;
        logic [FLE_BYTE_W-1:0] mk;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_START_MARKER;
        i_cfg_data  = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        frames_typed = 0;
        snd_idle_pct  = 8;
        rcv_stall_pct = 68;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part on reset markers
        for (int r = 0; r < DIR_ROWS_N; r++) begin
            row = DIR_ROWS[r];
            frames_typed += row[8];
            send_rx(row[7:0]);
        end
        drain_frames();
        if (frames_seen != frames_typed)
            note_mismatch($sformatf("directed part: %0d frames expected, %0d seen",
                                    frames_typed, frames_seen));

        // Random phases, markers at the extremes first
        write_markers(8'h00, 8'hFF);
        run_random(115);

        snd_idle_pct  = 68;
        rcv_stall_pct = 8;
        drain_frames();
        write_markers(8'hFF, 8'h00);
        run_random(115);

        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        drain_frames();
        mk = FLE_BYTE_W'($urandom_range(255));
        write_markers(mk, $urandom_range(1) ? mk : FLE_BYTE_W'($urandom_range(255)));
        run_random(115);

        drain_frames();
        if (frame_bytes_due.size() != 0)
            note_mismatch($sformatf("%0d frame bytes never came out", frame_bytes_due.size()));
        if (n_mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
src/fle_pkg.sv
src/fle_win_cell.sv
src/fle_out_cell.sv
src/fixed_length_frame_extractor.sv
src/fle_checker.sv
sim/fixed_length_frame_extractor_tb.sv
